@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
// Needs a clock named clk and a reset named rst in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is high.
`define LPST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked property, checked during reset as well.
`define LPST_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/lpst_pkg.sv @@
// Shared types and constants for the loop pair speed trap.
// No dependencies; used by every module of the block.
package lpst_pkg;

  localparam int DIGIT_W     = 4;
  localparam int SPEED_W     = 8;
  localparam int LIMIT_W     = 8;
  localparam int NUM_W       = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_LIMIT     = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_NUMERATOR = 1'b1;

  localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RESET     = 8'd60;
  localparam logic [NUM_W-1:0]   SPEED_NUMERATOR_RESET = 16'd1440;

  // timebase
  localparam int TENTH_W  = 4;
  localparam int SECTICK_W = 7;
  localparam int SEC_W    = 2;
  localparam logic [TENTH_W-1:0]   SHORT_TENTH      = 4'd12;
  localparam logic [TENTH_W-1:0]   LONG_TENTH       = 4'd13;
  localparam logic [SECTICK_W-1:0] TICKS_PER_SECOND = 7'd125;
  localparam logic [SEC_W-1:0]     SEC_FLASH_OFF    = 2'd1;
  localparam logic [SEC_W-1:0]     SEC_CLEAR        = 2'd3;

  // display
  localparam logic [SPEED_W-1:0] DISPLAY_MAX = 8'd99;
  localparam logic [SPEED_W-1:0] SPEED_MAX   = 8'd255;
  localparam logic [DIGIT_W-1:0] DIGIT_NINE  = 4'd9;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 4'd10;
  // x / 10 == (x * 205) >> 11 for x below 1024
  localparam logic [7:0] RECIP_TEN       = 8'd205;
  localparam int         RECIP_TEN_SHIFT = 11;
  localparam int         DIGVAL_W        = 7;

  // divider
  localparam int DIV_W     = 16;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/lpst_div.sv @@
// Restoring shift-subtract divider, one quotient bit per cycle.
// Depends on lpst_pkg.
module lpst_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lpst_pkg::DIV_W-1:0] dividend,
  input  logic [lpst_pkg::DIV_W-1:0] divisor,
  output lpst_pkg::div_stat_t        stat,
  output logic [lpst_pkg::DIV_W-1:0] quotient
);
  import lpst_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     quo;
  logic [DIV_W-1:0]     dsr;
  logic [DIV_W:0]       trial;

  assign trial = {rem, quo[DIV_W-1]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      // trial sign bit clear: divisor fits in the shifted remainder
      if (!trial[DIV_W]) begin
        rem <= trial[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= {rem[DIV_W-2:0], quo[DIV_W-1]};
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

@@ rtl/loop_pair_speed_trap_core.sv @@
// Loop pair speed trap: timebase, measurement sequencer and display state.
// Depends on lpst_pkg and lpst_div.
// Sequence: an accepted item moves to ST_FIN, which loads its result into the output
// registers; an exit-loop item with no entry loop and a nonzero tenths count first runs
// the divider in ST_DIV (16 divider steps). No new item is taken before the result is
// loaded; a held output stalls ST_FIN. Synchronous reset restores register defaults.
module loop_pair_speed_trap_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             func,
  input  logic                             entry_loop_active,
  input  logic                             exit_loop_active,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [lpst_pkg::DIGIT_W-1:0]     tens_digit,
  output logic [lpst_pkg::DIGIT_W-1:0]     units_digit,
  output logic                             flash_on,
  output logic [lpst_pkg::SPEED_W-1:0]     measured_speed,
  input  logic                             cfg_write,
  input  logic [lpst_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lpst_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lpst_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state;

  logic [LIMIT_W-1:0] speed_limit;
  logic [NUM_W-1:0]   speed_numerator;

  logic [TENTH_W-1:0]   tick_in_tenth,  tick_in_tenth_next;
  logic                 long_phase,     long_phase_next;
  logic [NUM_W-1:0]     tenths_count,   tenths_count_next;
  logic [SECTICK_W-1:0] tick_in_second, tick_in_second_next;
  logic [SEC_W-1:0]     elapsed_seconds, elapsed_seconds_next;
  logic [DIGIT_W-1:0]   shown_tens,     shown_tens_next;
  logic [DIGIT_W-1:0]   shown_units,    shown_units_next;
  logic                 flash_level,    flash_level_next;

  logic item_func, item_entry, item_exit;
  logic [SPEED_W-1:0] speed;

  logic accept, out_free, load, measure;
  logic [TENTH_W-1:0]   tit_inc;
  logic [SECTICK_W-1:0] tis_inc;
  logic [SEC_W-1:0]     es_step;
  logic [DIGVAL_W-1:0]  dig_val;
  logic [14:0]          dig_prod;
  logic [DIGIT_W-1:0]   dig_tens;
  logic [DIGVAL_W-1:0]  dig_units;

  div_stat_t        div_stat;
  logic [DIV_W-1:0] div_quo;

  assign in_stall = rst || (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign load     = (state == ST_FIN) && out_free;
  // both loops at once start no measurement; the entry loop clears the count
  assign measure  = func && exit_loop_active && !entry_loop_active && (tenths_count != '0);

  lpst_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && measure),
    .dividend (speed_numerator),
    .divisor  (tenths_count),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_limit     <= SPEED_LIMIT_RESET;
      speed_numerator <= SPEED_NUMERATOR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SPEED_LIMIT:     speed_limit     <= cfg_data[LIMIT_W-1:0];
        REG_SPEED_NUMERATOR: speed_numerator <= cfg_data[NUM_W-1:0];
      endcase
    end
  end

  // speed below 99 split into digits by reciprocal multiply
  assign dig_val   = speed[DIGVAL_W-1:0];
  assign dig_prod  = {1'b0, dig_val} * {7'd0, RECIP_TEN};
  assign dig_tens  = dig_prod[RECIP_TEN_SHIFT +: DIGIT_W];
  assign dig_units = dig_val - (DIGVAL_W'(dig_tens) * DIGVAL_W'(DIGIT_TEN));

  always_comb begin
    tick_in_tenth_next   = tick_in_tenth;
    long_phase_next      = long_phase;
    tenths_count_next    = tenths_count;
    tick_in_second_next  = tick_in_second;
    elapsed_seconds_next = elapsed_seconds;
    shown_tens_next      = shown_tens;
    shown_units_next     = shown_units;
    flash_level_next     = flash_level;
    tit_inc = tick_in_tenth + 1'b1;
    tis_inc = tick_in_second + 1'b1;
    es_step = elapsed_seconds + 1'b1;

    if (!item_func) begin
      tick_in_tenth_next  = tit_inc;
      tick_in_second_next = tis_inc;
      // tenths alternate 12 and 13 ticks
      if ((tit_inc >= SHORT_TENTH && !long_phase) || tit_inc >= LONG_TENTH) begin
        if (tenths_count != '1) begin
          tenths_count_next = tenths_count + 1'b1;
        end
        tick_in_tenth_next = '0;
        long_phase_next    = !long_phase;
      end
      if (tis_inc >= TICKS_PER_SECOND) begin
        elapsed_seconds_next = es_step;
        tick_in_second_next  = '0;
      end
    end else begin
      if (item_entry) begin
        tenths_count_next = '0;
      end
      if (item_exit) begin
        elapsed_seconds_next = '0;
        if (speed > speed_limit) begin
          flash_level_next = 1'b1;
        end
      end
    end

    if (elapsed_seconds_next == SEC_FLASH_OFF) begin
      flash_level_next = 1'b0;
    end
    if (elapsed_seconds_next == SEC_CLEAR) begin
      elapsed_seconds_next = '0;
      shown_tens_next      = '0;
      shown_units_next     = '0;
      flash_level_next     = 1'b0;
    end
    if (speed != '0) begin
      if (speed >= DISPLAY_MAX) begin
        shown_tens_next  = DIGIT_NINE;
        shown_units_next = DIGIT_NINE;
      end else begin
        shown_tens_next  = dig_tens;
        shown_units_next = dig_units[DIGIT_W-1:0];
      end
    end
  end

  // sequencer and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      tick_in_tenth   <= '0;
      long_phase      <= 1'b0;
      tenths_count    <= '0;
      tick_in_second  <= '0;
      elapsed_seconds <= '0;
      shown_tens      <= '0;
      shown_units     <= '0;
      flash_level     <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= measure ? ST_DIV : ST_FIN;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state           <= ST_IDLE;
            tick_in_tenth   <= tick_in_tenth_next;
            long_phase      <= long_phase_next;
            tenths_count    <= tenths_count_next;
            tick_in_second  <= tick_in_second_next;
            elapsed_seconds <= elapsed_seconds_next;
            shown_tens      <= shown_tens_next;
            shown_units     <= shown_units_next;
            flash_level     <= flash_level_next;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // item and payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_func  <= func;
      item_entry <= entry_loop_active;
      item_exit  <= exit_loop_active;
      speed      <= '0;
    end else if (state == ST_DIV && div_stat.done) begin
      speed <= (div_quo > DIV_W'(SPEED_MAX)) ? SPEED_MAX : div_quo[SPEED_W-1:0];
    end
    if (load) begin
      tens_digit     <= shown_tens_next;
      units_digit    <= shown_units_next;
      flash_on       <= flash_level_next;
      measured_speed <= speed;
    end
  end

endmodule

@@ rtl/lpst_checker.sv @@
// Port-level checks for loop_pair_speed_trap_core, attached by bind.
// Depends on lpst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lpst_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [lpst_pkg::DIGIT_W-1:0]     tens_digit,
  input logic [lpst_pkg::DIGIT_W-1:0]     units_digit,
  input logic                             flash_on,
  input logic [lpst_pkg::SPEED_W-1:0]     measured_speed
);
  import lpst_pkg::*;

  logic [SPEED_W-1:0] shown_value;
  logic               shown_ok;

  assign shown_value = SPEED_W'(tens_digit) * SPEED_W'(DIGIT_TEN) + SPEED_W'(units_digit);
  assign shown_ok    = (measured_speed >= DISPLAY_MAX) ?
                       (tens_digit == DIGIT_NINE && units_digit == DIGIT_NINE) :
                       (shown_value == measured_speed);

  `LPST_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `LPST_ASSERT(a_out_stable, out_valid && out_stall |=> $stable({tens_digit, units_digit, flash_on, measured_speed}), "stalled result changed")
  `LPST_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "new item taken while busy")
  `LPST_ASSERT(a_digit_range, out_valid |-> tens_digit <= DIGIT_NINE && units_digit <= DIGIT_NINE, "digit out of range")
  `LPST_ASSERT(a_speed_shown, out_valid && measured_speed != '0 |-> shown_ok, "display does not match speed")

endmodule

bind loop_pair_speed_trap_core lpst_checker u_lpst_checker (.*);
